// File: hdl/cielum_pkg.sv
// Shared widths, constants, register codes and types of the lightness-to-luminance map.
`default_nettype none

package cielum_pkg;

   // Field and format widths.
   localparam int LEVEL_WIDTH   = 16;
   localparam int FRACTION_BITS = 24;
   localparam int LEVEL_CFG_W   = 17;
   localparam int OUT_W         = 16;
   localparam int FRAC_W        = FRACTION_BITS + 1;
   localparam int LIGHT_W       = FRACTION_BITS + 7;
   localparam int LIN_SLICE_W   = FRACTION_BITS + 4;
   localparam int LIN_RECIP_W   = FRACTION_BITS - 6;
   localparam int CUB_RECIP_W   = FRACTION_BITS + 1;
   localparam int SUM_W         = OUT_W + 2;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 2;

   typedef logic [LEVEL_WIDTH-1:0]             level_type;
   typedef logic [LEVEL_CFG_W-1:0]             level_cfg_type;
   typedef logic [OUT_W-1:0]                   out_type;
   typedef logic [FRAC_W-1:0]                  frac_type;
   typedef logic [LIGHT_W-1:0]                 light_type;
   typedef logic [LIN_RECIP_W-1:0]             lin_recip_type;
   typedef logic [CUB_RECIP_W-1:0]             cub_recip_type;
   typedef logic [LIGHT_W+LIN_RECIP_W-1:0]     lin_prod_type;
   typedef logic [LIGHT_W+CUB_RECIP_W-1:0]     cub_prod_type;
   typedef logic [2*FRAC_W-1:0]                frac_prod_type;
   typedef logic [FRAC_W+OUT_W-1:0]            scale_prod_type;
   typedef logic [SUM_W-1:0]                   sum_type;
   typedef logic [CSR_DATA_W-1:0]              csr_data_type;
   typedef logic [CSR_INDEX_W-1:0]             csr_index_type;

   // Register indexes on the configuration port.
   localparam csr_index_type REG_INPUT_LEVELS   = 2'd0;
   localparam csr_index_type REG_OUTPUT_MINIMUM = 2'd1;
   localparam csr_index_type REG_OUTPUT_MAXIMUM = 2'd2;

   // Reset values of the registers and of the values derived from them.
   localparam level_cfg_type INPUT_LEVELS_RESET   = 17'd4096;
   localparam level_cfg_type FULL_SCALE_RESET     = 17'd4095;
   localparam out_type       OUTPUT_MINIMUM_RESET = 16'd0;
   localparam out_type       OUTPUT_MAXIMUM_RESET = 16'hFFFF;
   localparam out_type       SCALE_RESET          = 16'hFFFE;
   localparam out_type       OUT_MAX              = 16'hFFFF;

   // Fixed-point constants of the lightness curve.
   localparam frac_type  FRAC_ONE         = frac_type'(1) << FRACTION_BITS;
   localparam light_type LIGHT_GAIN       = light_type'(100);
   localparam light_type LIGHT_LIN_LIMIT  = light_type'(8) << FRACTION_BITS;
   localparam light_type LIGHT_CUB_OFFSET = light_type'(16) << FRACTION_BITS;
   localparam light_type LIN_GAIN         = light_type'(10);
   localparam light_type LIN_DIVISOR      = light_type'(9023);
   localparam light_type CUB_DIVISOR      = light_type'(116);

   // Reciprocals scaled by 2^LIGHT_W; the estimate they give is low by at most one.
   localparam lin_recip_type LIN_RECIP =
      lin_recip_type'((64'd1 << LIGHT_W) / 64'd9023);
   localparam cub_recip_type CUB_RECIP =
      cub_recip_type'((64'd1 << LIGHT_W) / 64'd116);

   // Request entering the fraction divider.
   typedef struct packed {
      logic      valid;
      level_type level;
   } div_in_type;

   // Lightness fraction leaving the divider.
   typedef struct packed {
      logic     valid;
      logic     clamped;
      frac_type fraction;
   } div_out_type;

endpackage

`default_nettype wire

// File: hdl/cie_lightness_to_luminance_map.sv
// Top level of the CIE lightness-to-luminance map: registers, divider and curve pipeline.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_level
//   rsp      out        rsp_valid / rsp_ready     rsp_drive_value, rsp_input_clamped
//   csr      in/out     csr_psel / csr_penable    csr_paddr, csr_pwdata, csr_prdata
//
// One request is taken per clock while the output is not stalled; each result passes
// the fraction divider's entry and one-bit-per-stage quotient stages, then stages 1 to 6.
// Reset is synchronous and clears all valid bits and restores the register defaults.
// When a result waits at the output, the whole pipeline holds and no request is taken;
// bubbles ahead of the output still drain only while the output moves.
`default_nettype none

module cie_lightness_to_luminance_map (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [cielum_pkg::LEVEL_WIDTH-1:0]   req_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cielum_pkg::OUT_W-1:0]         rsp_drive_value,
   output logic                                 rsp_input_clamped,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cielum_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cielum_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cielum_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   // Configuration registers and derived values.
   cielum_pkg::level_cfg_type levels_ff, levels_in;
   cielum_pkg::level_cfg_type full_scale_ff, full_scale_in;
   cielum_pkg::out_type       minimum_ff, minimum_in;
   cielum_pkg::out_type       maximum_ff, maximum_in;
   cielum_pkg::out_type       scale_ff, scale_in;
   logic                      scale_off_ff, scale_off_in;

   logic                      csr_write;
   cielum_pkg::csr_index_type csr_index;
   cielum_pkg::level_cfg_type wr_levels;

   logic                      advance;
   cielum_pkg::div_in_type    div_in;
   cielum_pkg::div_out_type   div_out;

   // Pipeline stage registers behind the divider.
   logic                      p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic                      p4_valid_ff, p5_valid_ff, p6_valid_ff;
   logic                      p1_clamp_ff, p2_clamp_ff, p3_clamp_ff;
   logic                      p4_clamp_ff, p5_clamp_ff, p6_clamp_ff;
   logic                      p1_sel_ff, p2_sel_ff, p3_sel_ff, p4_sel_ff;
   logic                      p1_sel_in;
   cielum_pkg::light_type     p1_lin_n_ff, p1_lin_n_in, p1_cub_n_ff, p1_cub_n_in;
   cielum_pkg::light_type     p2_lin_n_ff, p2_cub_n_ff;
   cielum_pkg::frac_type      p2_lin_q_ff, p2_lin_q_in, p2_cub_q_ff, p2_cub_q_in;
   cielum_pkg::frac_type      p3_y_lin_ff, p3_y_lin_in, p3_t_ff, p3_t_in;
   cielum_pkg::frac_type      p4_y_lin_ff, p4_t_ff, p4_u_ff, p4_u_in;
   cielum_pkg::frac_type      p5_y_ff, p5_y_in;
   cielum_pkg::out_type       p6_drive_ff, p6_drive_in;

   cielum_pkg::light_type      light;
   cielum_pkg::lin_prod_type   lin_prod;
   cielum_pkg::cub_prod_type   cub_prod;
   cielum_pkg::light_type      lin_rem, cub_rem;
   cielum_pkg::frac_prod_type  sq_prod, cu_prod;
   cielum_pkg::frac_type       y_cub;
   cielum_pkg::scale_prod_type sc_prod;
   cielum_pkg::sum_type        drive_sum;

   // Register port decode and write values.
   always_comb begin
      csr_write  = csr_psel && csr_penable && csr_pwrite;
      csr_index  = csr_paddr[cielum_pkg::CSR_ADDR_W-1:2];
      wr_levels  = csr_pwdata[cielum_pkg::LEVEL_CFG_W-1:0];
      levels_in     = levels_ff;
      full_scale_in = full_scale_ff;
      minimum_in    = minimum_ff;
      maximum_in    = maximum_ff;
      if (csr_write) begin
         unique case (csr_index)
            cielum_pkg::REG_INPUT_LEVELS: begin
               levels_in     = wr_levels;
               // Fewer than two levels act as two, so the full scale is at least one.
               full_scale_in = (wr_levels < cielum_pkg::level_cfg_type'(2))
                             ? cielum_pkg::level_cfg_type'(1)
                             : wr_levels - cielum_pkg::level_cfg_type'(1);
            end
            cielum_pkg::REG_OUTPUT_MINIMUM: begin
               minimum_in = csr_pwdata[cielum_pkg::OUT_W-1:0];
            end
            cielum_pkg::REG_OUTPUT_MAXIMUM: begin
               maximum_in = csr_pwdata[cielum_pkg::OUT_W-1:0];
            end
            default: begin
            end
         endcase
      end
      // The scale is only used at the last stage, long after any request enters.
      scale_in     = maximum_ff - minimum_ff - cielum_pkg::out_type'(1);
      scale_off_in = maximum_ff <= minimum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff     <= cielum_pkg::INPUT_LEVELS_RESET;
         full_scale_ff <= cielum_pkg::FULL_SCALE_RESET;
         minimum_ff    <= cielum_pkg::OUTPUT_MINIMUM_RESET;
         maximum_ff    <= cielum_pkg::OUTPUT_MAXIMUM_RESET;
         scale_ff      <= cielum_pkg::SCALE_RESET;
         scale_off_ff  <= 1'b0;
      end else begin
         levels_ff     <= levels_in;
         full_scale_ff <= full_scale_in;
         minimum_ff    <= minimum_in;
         maximum_ff    <= maximum_in;
         scale_ff      <= scale_in;
         scale_off_ff  <= scale_off_in;
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         cielum_pkg::REG_INPUT_LEVELS:   csr_prdata = cielum_pkg::csr_data_type'(levels_ff);
         cielum_pkg::REG_OUTPUT_MINIMUM: csr_prdata = cielum_pkg::csr_data_type'(minimum_ff);
         cielum_pkg::REG_OUTPUT_MAXIMUM: csr_prdata = cielum_pkg::csr_data_type'(maximum_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // The pipeline moves whenever the output register is empty or being drained.
   assign advance   = !p6_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      div_in.valid = req_valid;
      div_in.level = req_level;
   end

   cielum_frac_div u_frac_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .full_scale (full_scale_ff),
      .div_in     (div_in),
      .div_out    (div_out)
   );

   // Stage 1: lightness L = 100 * f and the numerators of both branches.
   always_comb begin
      light       = cielum_pkg::light_type'(div_out.fraction) * cielum_pkg::LIGHT_GAIN;
      p1_sel_in   = light <= cielum_pkg::LIGHT_LIN_LIMIT;
      p1_lin_n_in = cielum_pkg::light_type'(light[cielum_pkg::LIN_SLICE_W-1:0])
                  * cielum_pkg::LIN_GAIN;
      p1_cub_n_in = light + cielum_pkg::LIGHT_CUB_OFFSET;
   end

   // Stage 2: quotient estimates through the scaled reciprocals.
   always_comb begin
      lin_prod    = cielum_pkg::lin_prod_type'(p1_lin_n_ff)
                  * cielum_pkg::lin_prod_type'(cielum_pkg::LIN_RECIP);
      cub_prod    = cielum_pkg::cub_prod_type'(p1_cub_n_ff)
                  * cielum_pkg::cub_prod_type'(cielum_pkg::CUB_RECIP);
      p2_lin_q_in = cielum_pkg::frac_type'(lin_prod >> cielum_pkg::LIGHT_W);
      p2_cub_q_in = cielum_pkg::frac_type'(cub_prod >> cielum_pkg::LIGHT_W);
   end

   // Stage 3: correct each estimate by one where the remainder reaches the divisor.
   always_comb begin
      lin_rem     = p2_lin_n_ff
                  - cielum_pkg::light_type'(p2_lin_q_ff) * cielum_pkg::LIN_DIVISOR;
      cub_rem     = p2_cub_n_ff
                  - cielum_pkg::light_type'(p2_cub_q_ff) * cielum_pkg::CUB_DIVISOR;
      p3_y_lin_in = (lin_rem >= cielum_pkg::LIN_DIVISOR)
                  ? p2_lin_q_ff + cielum_pkg::frac_type'(1) : p2_lin_q_ff;
      p3_t_in     = (cub_rem >= cielum_pkg::CUB_DIVISOR)
                  ? p2_cub_q_ff + cielum_pkg::frac_type'(1) : p2_cub_q_ff;
   end

   // Stage 4: square of t.
   always_comb begin
      sq_prod = cielum_pkg::frac_prod_type'(p3_t_ff) * cielum_pkg::frac_prod_type'(p3_t_ff);
      p4_u_in = cielum_pkg::frac_type'(sq_prod >> cielum_pkg::FRACTION_BITS);
   end

   // Stage 5: cube of t and branch selection.
   always_comb begin
      cu_prod = cielum_pkg::frac_prod_type'(p4_u_ff) * cielum_pkg::frac_prod_type'(p4_t_ff);
      y_cub   = cielum_pkg::frac_type'(cu_prod >> cielum_pkg::FRACTION_BITS);
      p5_y_in = p4_sel_ff ? p4_y_lin_ff : y_cub;
   end

   // Stage 6: scale, offset, saturate; a negative scale gives zero.
   always_comb begin
      sc_prod   = cielum_pkg::scale_prod_type'(p5_y_ff)
                * cielum_pkg::scale_prod_type'(scale_ff);
      drive_sum = cielum_pkg::sum_type'(sc_prod >> cielum_pkg::FRACTION_BITS)
                + cielum_pkg::sum_type'(minimum_ff);
      if (scale_off_ff) begin
         p6_drive_in = '0;
      end else if (drive_sum[cielum_pkg::SUM_W-1:cielum_pkg::OUT_W] != '0) begin
         p6_drive_in = cielum_pkg::OUT_MAX;
      end else begin
         p6_drive_in = drive_sum[cielum_pkg::OUT_W-1:0];
      end
   end

   // Valid bits of the curve stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= div_out.valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
         p6_valid_ff <= p5_valid_ff;
      end
   end

   // Payload of the curve stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_clamp_ff <= div_out.clamped;
         p1_sel_ff   <= p1_sel_in;
         p1_lin_n_ff <= p1_lin_n_in;
         p1_cub_n_ff <= p1_cub_n_in;

         p2_clamp_ff <= p1_clamp_ff;
         p2_sel_ff   <= p1_sel_ff;
         p2_lin_n_ff <= p1_lin_n_ff;
         p2_cub_n_ff <= p1_cub_n_ff;
         p2_lin_q_ff <= p2_lin_q_in;
         p2_cub_q_ff <= p2_cub_q_in;

         p3_clamp_ff <= p2_clamp_ff;
         p3_sel_ff   <= p2_sel_ff;
         p3_y_lin_ff <= p3_y_lin_in;
         p3_t_ff     <= p3_t_in;

         p4_clamp_ff <= p3_clamp_ff;
         p4_sel_ff   <= p3_sel_ff;
         p4_y_lin_ff <= p3_y_lin_ff;
         p4_t_ff     <= p3_t_ff;
         p4_u_ff     <= p4_u_in;

         p5_clamp_ff <= p4_clamp_ff;
         p5_y_ff     <= p5_y_in;

         p6_clamp_ff <= p5_clamp_ff;
         p6_drive_ff <= p6_drive_in;
      end
   end

   assign rsp_valid         = p6_valid_ff;
   assign rsp_drive_value   = p6_drive_ff;
   assign rsp_input_clamped = p6_clamp_ff;

endmodule

`default_nettype wire

// File: hdl/cielum_frac_div.sv
// Pipelined restoring divider that forms the lightness fraction level * 2^F / full scale.
`default_nettype none

module cielum_frac_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  cielum_pkg::level_cfg_type full_scale,
   input  cielum_pkg::div_in_type    div_in,
   output cielum_pkg::div_out_type   div_out
);

   localparam int STAGES = cielum_pkg::FRACTION_BITS;

   logic                      st_valid_ff [0:STAGES];
   logic                      st_clamp_ff [0:STAGES];
   cielum_pkg::level_cfg_type st_rem_ff   [0:STAGES];
   cielum_pkg::frac_type      st_quo_ff   [0:STAGES];

   cielum_pkg::level_cfg_type level_ext;
   logic                      level_full;
   logic                      clamp0_in;
   cielum_pkg::level_cfg_type rem0_in;
   cielum_pkg::frac_type      quo0_in;

   // Entry stage: clamp the level; at or above full scale the fraction is exactly one.
   always_comb begin
      level_ext  = cielum_pkg::level_cfg_type'(div_in.level);
      level_full = level_ext >= full_scale;
      clamp0_in  = level_ext > full_scale;
      rem0_in    = level_full ? '0 : level_ext;
      quo0_in    = level_full ? cielum_pkg::FRAC_ONE : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         st_valid_ff[0] <= div_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_clamp_ff[0] <= clamp0_in;
         st_rem_ff[0]   <= rem0_in;
         st_quo_ff[0]   <= quo0_in;
      end
   end

   // One quotient bit per stage, most significant fraction bit first.
   for (genvar k = 1; k <= STAGES; k++) begin : g_stage
      logic [cielum_pkg::LEVEL_CFG_W:0] dbl;
      logic                             ge;
      cielum_pkg::level_cfg_type        rem_in;
      cielum_pkg::frac_type             quo_in;

      always_comb begin
         dbl    = {st_rem_ff[k-1], 1'b0};
         ge     = dbl >= {1'b0, full_scale};
         rem_in = ge ? cielum_pkg::level_cfg_type'(dbl - {1'b0, full_scale})
                     : cielum_pkg::level_cfg_type'(dbl);
         quo_in = st_quo_ff[k-1];
         quo_in[STAGES-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            st_valid_ff[k] <= st_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            st_clamp_ff[k] <= st_clamp_ff[k-1];
            st_rem_ff[k]   <= rem_in;
            st_quo_ff[k]   <= quo_in;
         end
      end
   end

   // Last stage holds the finished fraction.
   always_comb begin
      div_out.valid    = st_valid_ff[STAGES];
      div_out.clamped  = st_clamp_ff[STAGES];
      div_out.fraction = st_quo_ff[STAGES];
   end

endmodule

`default_nettype wire

// File: hdl/cielum_checker.sv
// Port-level checker for the lightness-to-luminance map, bound to the top level.
`default_nettype none

module cielum_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [cielum_pkg::OUT_W-1:0]         rsp_drive_value,
   input logic                                 rsp_input_clamped,
   input logic                                 csr_psel,
   input logic                                 csr_pready
);

   // A stalled result stays in place with its payload unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_value)
                                 && $stable(rsp_input_clamped))
      else $error("stalled result changed or dropped");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The pipeline takes a request whenever the output is empty or being drained.
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the output stage");

   // The register port never inserts wait states.
   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port not ready");

endmodule

bind cie_lightness_to_luminance_map cielum_checker u_cielum_checker (.*);

`default_nettype wire
